### rtl/aaq_pkg.sv
// shared constants, cordic angle table and output saturation for the quaternion block
`default_nettype none
package aaq_pkg;

  localparam int AAQ_FRACTION_BITS = 14;
  localparam int AAQ_SQRT_STEPS    = 32;
  localparam int AAQ_DIV_STEPS     = 31;
  localparam int AAQ_CORDIC_STEPS  = 30;

  localparam logic signed [32:0] AAQ_INV_GAIN = 33'sd652032874;

  localparam logic [31:0] AAQ_ATAN [AAQ_CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // clamp to [lo, hi], both already within the 16-bit range
  function automatic logic [15:0] aaq_sat(input logic signed [65:0] v,
                                          input logic signed [65:0] hi,
                                          input logic signed [65:0] lo);
    logic signed [65:0] c;
    begin
      c = v;
      if (c > hi) c = hi;
      if (c < lo) c = lo;
      return c[15:0];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/axis_angle_to_quaternion.sv
// Axis-angle to unit quaternion converter.
// Input word: axis_x/y/z (signed, any scale) and angle (4*pi/65536 rad per unit),
// taken when axis_valid is high and axis_stall is low.
// Output word: quat_w/x/y/z in signed fixed point with FRACTION_BITS fraction
// bits plus degenerate_axis, offered on quat_valid and taken when quat_stall
// is low. A zero axis yields the identity with degenerate_axis set.
// The path is a square stage, a sum stage, 32 square-root cells
// (the 30 cordic cells run beside the first 30 of them), 31 divider cells,
// a multiply stage and the output register.
// Throughput is one word per cycle unless stalled; each stage is one register deep.
// When the receiver stalls with a word waiting, the whole chain holds and
// axis_stall rises; it drops in the cycle the waiting word is taken.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module axis_angle_to_quaternion
  import aaq_pkg::*;
#(
  parameter int FRACTION_BITS = AAQ_FRACTION_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               axis_valid,
  output logic                    axis_stall,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z,
  input  wire logic signed [15:0] angle,
  output logic                    quat_valid,
  input  wire logic               quat_stall,
  output logic signed      [15:0] quat_w,
  output logic signed      [15:0] quat_x,
  output logic signed      [15:0] quat_y,
  output logic signed      [15:0] quat_z,
  output logic                    degenerate_axis
);

  localparam int NS = AAQ_SQRT_STEPS;
  localparam int ND = AAQ_DIV_STEPS;
  localparam int NC = AAQ_CORDIC_STEPS;
  localparam int CS = 30 - FRACTION_BITS;
  localparam int PS = 60 - FRACTION_BITS;
  localparam logic signed [33:0] CHALF = (CS == 0) ? 34'sd0 :
                                         (34'sd1 <<< ((CS == 0) ? 0 : CS - 1));
  localparam logic signed [65:0] PHALF = 66'sd1 <<< (PS - 1);
  localparam logic signed [65:0] ONE   = 66'sd1 <<< FRACTION_BITS;
  localparam logic signed [65:0] HI    = (ONE > 66'sd32767) ? 66'sd32767 : ONE;
  localparam logic signed [65:0] LO    = (-ONE < -66'sd32768) ? -66'sd32768 : -ONE;

  logic en;
  assign en         = !(quat_valid && quat_stall);
  assign axis_stall = !en;

  // square stage
  logic        va;
  logic [30:0] sqa [3];
  logic [15:0] maga [3];
  logic [2:0]  sgna;
  logic signed [32:0] ta;
  logic        nega;

  logic signed [15:0] ain [3];
  logic [15:0]        amag [3];
  logic signed [32:0] t_next;
  logic               neg_next;

  assign ain[0] = axis_x;
  assign ain[1] = axis_y;
  assign ain[2] = axis_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = ain[i][15] ? 16'(-ain[i]) : 16'(ain[i]);
    end
    t_next   = {angle[15], angle, 16'd0};
    neg_next = 1'b0;
    // fold the half angle into [-pi/2, pi/2], flipping sign
    if (angle > 16'sd16384) begin
      t_next   = t_next - 33'sd2147483648;
      neg_next = 1'b1;
    end else if (angle < -16'sd16384) begin
      t_next   = t_next + 33'sd2147483648;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= axis_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqa[i]  <= 31'(amag[i] * amag[i]);
        maga[i] <= amag[i];
        sgna[i] <= ain[i][15];
      end
      ta   <= t_next;
      nega <= neg_next;
    end
  end

  // sum stage
  logic        vb;
  logic [31:0] sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb <= 32'(sqa[0]) + 32'(sqa[1]) + 32'(sqa[2]);
    end
  end

  // square root chain with cordic alongside
  logic [63:0]        s_op  [NS+1];
  logic [63:0]        s_res [NS+1];
  logic               s_v   [NS+1];
  logic [15:0]        s_mag [NS+1][3];
  logic [2:0]         s_sgn [NS+1];
  logic               s_neg [NS+1];
  logic               s_deg [NS+1];
  logic signed [32:0] c_x   [NS+1];
  logic signed [32:0] c_y   [NS+1];
  logic signed [32:0] c_z   [NC+1];
  logic signed [32:0] tb;
  logic [15:0]        magb [3];
  logic [2:0]         sgnb;
  logic               negb;

  always_ff @(posedge clk) begin
    if (en) begin
      tb   <= ta;
      magb <= maga;
      sgnb <= sgna;
      negb <= nega;
    end
  end

  assign s_op[0]  = {sb, 32'd0};
  assign s_res[0] = 64'd0;
  assign s_v[0]   = vb;
  assign s_mag[0] = magb;
  assign s_sgn[0] = sgnb;
  assign s_neg[0] = negb;
  assign s_deg[0] = (sb == 32'd0);
  assign c_x[0]   = AAQ_INV_GAIN;
  assign c_y[0]   = 33'sd0;
  assign c_z[0]   = tb;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    aaq_sqrt_step #(.STEP(k)) u_step (
      .clk(clk), .en(en),
      .op_in(s_op[k]), .res_in(s_res[k]),
      .op(s_op[k+1]), .res(s_res[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[k+1] <= 1'b0;
      end else if (en) begin
        s_v[k+1] <= s_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_mag[k+1] <= s_mag[k];
        s_sgn[k+1] <= s_sgn[k];
        s_neg[k+1] <= s_neg[k];
        s_deg[k+1] <= s_deg[k];
      end
    end

    if (k < NC) begin : g_rot
      aaq_cordic_step #(.STEP(k)) u_rot (
        .clk(clk), .en(en),
        .x_in(c_x[k]), .y_in(c_y[k]), .z_in(c_z[k]),
        .x(c_x[k+1]), .y(c_y[k+1]), .z(c_z[k+1])
      );
    end else begin : g_dly
      always_ff @(posedge clk) begin
        if (en) begin
          c_x[k+1] <= c_x[k];
          c_y[k+1] <= c_y[k];
        end
      end
    end
  end

  // divider chain, three lanes per stage
  logic [31:0]        d_r   [ND+1];
  logic [62:0]        d_rem [ND+1][3];
  logic [30:0]        d_q   [ND+1][3];
  logic               d_v   [ND+1];
  logic [2:0]         d_sgn [ND+1];
  logic               d_deg [ND+1];
  logic signed [32:0] d_cos [ND+1];
  logic signed [32:0] d_sin [ND+1];

  assign d_r[0]   = s_res[NS][31:0];
  assign d_v[0]   = s_v[NS];
  assign d_sgn[0] = s_sgn[NS];
  assign d_deg[0] = s_deg[NS];
  assign d_cos[0] = s_neg[NS] ? -c_x[NS] : c_x[NS];
  assign d_sin[0] = s_neg[NS] ? -c_y[NS] : c_y[NS];

  for (genvar i = 0; i < 3; i++) begin : g_lane_in
    assign d_rem[0][i] = {1'b0, s_mag[NS][i], 46'd0};
    assign d_q[0][i]   = 31'd0;
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      aaq_div_step #(.STEP(j)) u_step (
        .clk(clk), .en(en), .dvs(d_r[j]),
        .rem_in(d_rem[j][i]), .q_in(d_q[j][i]),
        .rem(d_rem[j+1][i]), .q(d_q[j+1][i])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[j+1] <= 1'b0;
      end else if (en) begin
        d_v[j+1] <= d_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j+1]   <= d_r[j];
        d_sgn[j+1] <= d_sgn[j];
        d_deg[j+1] <= d_deg[j];
        d_cos[j+1] <= d_cos[j];
        d_sin[j+1] <= d_sin[j];
      end
    end
  end

  // multiply stage
  logic               vm;
  logic               degm;
  logic signed [33:0] cosm;
  logic signed [64:0] prodm [3];
  logic signed [31:0] nval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nval[i] = d_sgn[ND][i] ? -$signed({1'b0, d_q[ND][i]}) : $signed({1'b0, d_q[ND][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= d_v[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degm <= d_deg[ND];
      cosm <= (34'(d_cos[ND]) + CHALF) >>> CS;
      for (int i = 0; i < 3; i++) begin
        prodm[i] <= d_sin[ND] * nval[i];
      end
    end
  end

  // round, saturate, output register
  logic signed [65:0] pr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i] = (66'(prodm[i]) + PHALF) >>> PS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en) begin
      quat_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate_axis <= degm;
      if (degm) begin
        quat_w <= aaq_sat(ONE, HI, LO);
        quat_x <= 16'sd0;
        quat_y <= 16'sd0;
        quat_z <= 16'sd0;
      end else begin
        quat_w <= aaq_sat(66'(cosm), HI, LO);
        quat_x <= aaq_sat(pr[0], HI, LO);
        quat_y <= aaq_sat(pr[1], HI, LO);
        quat_z <= aaq_sat(pr[2], HI, LO);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/aaq_sqrt_step.sv
// one bit of the restoring square root, registered
`default_nettype none
module aaq_sqrt_step
  import aaq_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] op_in,
  input  wire logic [63:0] res_in,
  output logic      [63:0] op,
  output logic      [63:0] res
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic [63:0] op_next;
  logic [63:0] res_next;

  always_comb begin
    trial = res_in + BIT;
    if (op_in >= trial) begin
      op_next  = op_in - trial;
      res_next = (res_in >> 1) + BIT;
    end else begin
      op_next  = op_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op  <= op_next;
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

### rtl/aaq_div_step.sv
// one quotient bit of the restoring divider, registered
`default_nettype none
module aaq_div_step
  import aaq_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] dvs,
  input  wire logic [62:0] rem_in,
  input  wire logic [30:0] q_in,
  output logic      [62:0] rem,
  output logic      [30:0] q
);

  localparam int K = AAQ_DIV_STEPS - 1 - STEP;

  logic [62:0] trial;
  logic [62:0] rem_next;
  logic [30:0] q_next;

  always_comb begin
    trial    = {31'd0, dvs} << K;
    rem_next = rem_in;
    q_next   = q_in;
    if (rem_in >= trial) begin
      rem_next  = rem_in - trial;
      q_next[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      q   <= q_next;
    end
  end

endmodule
`default_nettype wire

### rtl/aaq_cordic_step.sv
// one rotation step of the sine/cosine cordic, registered
`default_nettype none
module aaq_cordic_step
  import aaq_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] x_in,
  input  wire logic signed [32:0] y_in,
  input  wire logic signed [32:0] z_in,
  output logic signed      [32:0] x,
  output logic signed      [32:0] y,
  output logic signed      [32:0] z
);

  localparam logic signed [32:0] ANG = $signed({1'b0, AAQ_ATAN[STEP]});

  logic signed [32:0] xs;
  logic signed [32:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[32]) begin
        x <= x_in - ys;
        y <= y_in + xs;
        z <= z_in - ANG;
      end else begin
        x <= x_in + ys;
        y <= y_in - xs;
        z <= z_in + ANG;
      end
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the axis-angle to quaternion converter: predicted words checked in order
`default_nettype none
module tb;
  import aaq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = AAQ_FRACTION_BITS;
  localparam int LATENCY = 67;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic axis_valid = 1'b0;
  logic axis_stall;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
  logic quat_valid;
  logic quat_stall = 1'b0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic degenerate_axis;

  quat_t expected_quats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_random = 1'b1;

  always #1 clk = ~clk;

  axis_angle_to_quaternion uut (
    .clk(clk), .rst(rst),
    .axis_valid(axis_valid), .axis_stall(axis_stall),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
    .quat_valid(quat_valid), .quat_stall(quat_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .degenerate_axis(degenerate_axis)
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] clamp_unit(longint v);
    longint one;
    one = longint'(1) << FB;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint round_down(longint v, int s);
    if (s == 0) return v;
    return floor_shift(v + (longint'(1) << (s - 1)), s);
  endfunction

  // product of Q30 sine and Q2.30 unit component, rounded to FB fraction bits
  function automatic logic signed [15:0] scale_vec(longint s, longint n);
    logic signed [127:0] p;
    logic signed [127:0] r;
    int sh;
    sh = 60 - FB;
    p = 128'(s) * 128'(n);
    r = (p + (128'sd1 <<< (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return clamp_unit(longint'(r));
  endfunction

  function automatic quat_t predict_quat(logic signed [15:0] ax, logic signed [15:0] ay,
                                         logic signed [15:0] az, logic signed [15:0] ang);
    quat_t q;
    longint comp[3];
    longint unit[3];
    longint t, cx, cy, cz, nx;
    logic [63:0] sumsq, op, res, bit_v, mag;
    bit flip;
    comp[0] = ax; comp[1] = ay; comp[2] = az;
    sumsq = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
    if (sumsq == 0) begin
      q.w = clamp_unit(longint'(1) << FB);
      q.x = '0; q.y = '0; q.z = '0; q.degen = 1'b1;
      return q;
    end
    op = sumsq << 32;
    res = 0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (op >= res + bit_v) begin
        op = op - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 3; i++) begin
      mag = 64'(comp[i] < 0 ? -comp[i] : comp[i]) << 46;
      unit[i] = longint'(mag / res);
      if (comp[i] < 0) unit[i] = -unit[i];
    end
    // half angle as a binary angle, folded into +-quarter turn
    t = longint'(int'({ang, 16'h0000}));
    flip = 1'b0;
    if (t > (longint'(1) << 30)) begin
      t -= longint'(1) << 31; flip = 1'b1;
    end else if (t < -(longint'(1) << 30)) begin
      t += longint'(1) << 31; flip = 1'b1;
    end
    cx = longint'(AAQ_INV_GAIN);
    cy = 0;
    cz = t;
    for (int i = 0; i < AAQ_CORDIC_STEPS; i++) begin
      if (cz >= 0) begin
        nx = cx - floor_shift(cy, i);
        cy = cy + floor_shift(cx, i);
        cz -= longint'(AAQ_ATAN[i]);
      end else begin
        nx = cx + floor_shift(cy, i);
        cy = cy - floor_shift(cx, i);
        cz += longint'(AAQ_ATAN[i]);
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    q.w = clamp_unit(round_down(cx, 30 - FB));
    q.x = scale_vec(cy, unit[0]);
    q.y = scale_vec(cy, unit[1]);
    q.z = scale_vec(cy, unit[2]);
    q.degen = 1'b0;
    return q;
  endfunction

  // result side: random stall, compare against oldest prediction
  always @(posedge clk) begin
    quat_t e;
    int w;
    if (rst) begin
      quat_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if ((axis_valid && !axis_stall) || (quat_valid && !quat_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (quat_valid && !quat_stall) begin
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word w=%0d x=%0d y=%0d z=%0d",
                                         quat_w, quat_x, quat_y, quat_z);
        end else begin
          e = expected_quats.pop_front();
          if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y || quat_z !== e.z ||
              degenerate_axis !== e.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp w=%0d x=%0d y=%0d z=%0d d=%0b got w=%0d x=%0d y=%0d z=%0d d=%0b",
                       e.w, e.x, e.y, e.z, e.degen,
                       quat_w, quat_x, quat_y, quat_z, degenerate_axis);
          end
        end
      end
      // per word, hold stall for a drawn number of cycles
      if (!stall_random) begin
        quat_stall <= 1'b0;
        stall_left <= 0;
      end else if (quat_valid && !quat_stall) begin
        w = $urandom_range(0, 14);
        stall_left <= w;
        quat_stall <= (w > 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        quat_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  bit gaps_on = 1'b1;

  task automatic send_word(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] az, logic signed [15:0] ang);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      axis_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    axis_valid <= 1'b1;
    axis_x <= ax; axis_y <= ay; axis_z <= az; angle <= ang;
    expected_quats.push_back(predict_quat(ax, ay, az, ang));
    @(posedge clk);
    while (axis_stall) @(posedge clk);
  endtask

  task automatic drain();
    axis_valid <= 1'b0;
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_word(0, 0, 0, 0);
    send_word(0, 0, 0, 16'sh7fff);
    send_word(-32768, -32768, -32768, -32768);
    send_word(32767, 32767, 32767, 32767);
    send_word(-32768, 0, 0, 16'sh4000);
    send_word(0, 32767, 0, -16384);
    send_word(0, 0, 1, 16'sh2000);
    send_word(1, 1, 1, 1);
    send_word(-1, 0, 0, -1);
    send_word(32767, -32768, 1, 0);
    send_word(3, 4, 0, 16'sh5555);
    send_word(0, 0, -1, 16'sh8001);
    send_word(12, -5, 0, 16'sh3fff);
    send_word(0, 0, 0, -32768);
  endtask

  task automatic test_flip_boundary();
    // half angle just around plus and minus a quarter turn
    send_word(100, 200, 300, 16'sh4001);
    send_word(100, 200, 300, 16'shbfff);
    send_word(-7, 9, -11, 16'shc000);
    send_word(-7, 9, -11, 16'sh4000);
    // pause until the pipeline is empty
    drain();
  endtask

  task automatic test_random(int count);
    logic signed [15:0] v[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0: v[k] = 16'($urandom_range(0, 6)) - 16'sd3;
          1: v[k] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          default: v[k] = 16'($urandom);
        endcase
      end
      if ($urandom_range(0, 30) == 0) v = '{16'sd0, 16'sd0, 16'sd0};
      if (n == count / 2) begin
        gaps_on = 1'b0;
        stall_random = 1'b0;
      end
      if (n == count / 2 + 150) begin
        gaps_on = 1'b1;
        stall_random = 1'b1;
      end
      send_word(v[0], v[1], v[2], 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_flip_boundary();
    test_random(1100);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/aaq_pkg.sv
rtl/aaq_sqrt_step.sv
rtl/aaq_div_step.sv
rtl/aaq_cordic_step.sv
rtl/axis_angle_to_quaternion.sv
tb/tb.sv
